// File: rtl/core/aru_pkg.sv
// Shared types, request codes, S-box tables and GF(2^8) helpers for the AES round unit.
// Depends on nothing; aru_round and aes_round_unit import it.
package aru_pkg;

    typedef logic [7:0]   t_byte;
    typedef logic [31:0]  t_word;
    typedef logic [127:0] t_block;
    typedef t_byte        t_byte_tab [256];

    // Request codes; the unused code behaves as key XOR only
    typedef enum logic [1:0] {
        REQ_FWD = 2'd0,
        REQ_INV = 2'd1,
        REQ_ARK = 2'd2
    } t_req;

    localparam t_byte GF_POLY = 8'h1b;

    localparam t_byte_tab SBOX = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // Build the reverse S-box from the forward one at elaboration
    function automatic t_byte_tab build_rev_sbox();
        t_byte_tab tab;
        for (int i = 0; i < 256; i++) begin
            tab[SBOX[i]] = i[7:0];
        end
        return tab;
    endfunction

    localparam t_byte_tab REV_SBOX = build_rev_sbox();

    // Multiply by x in GF(2^8)
    function automatic t_byte xtime(input t_byte b);
        return {b[6:0], 1'b0} ^ (b[7] ? GF_POLY : 8'h00);
    endfunction

    // MixColumns on one column, row 0 byte in the top bits
    function automatic t_word mix_col_fwd(input t_word col);
        t_byte a [4];
        t_word res;
        for (int k = 0; k < 4; k++) begin
            a[k] = col[31 - 8 * k -: 8];
        end
        for (int r = 0; r < 4; r++) begin
            res[31 - 8 * r -: 8] = xtime(a[r]) ^ xtime(a[(r + 1) % 4]) ^ a[(r + 1) % 4]
                                 ^ a[(r + 2) % 4] ^ a[(r + 3) % 4];
        end
        return res;
    endfunction

    // InvMixColumns on one column: coefficients 0e, 0b, 0d, 09 rotated per row
    function automatic t_word mix_col_inv(input t_word col);
        t_byte a [4];
        t_byte x2 [4];
        t_byte x4 [4];
        t_byte x8 [4];
        t_word res;
        for (int k = 0; k < 4; k++) begin
            a[k]  = col[31 - 8 * k -: 8];
            x2[k] = xtime(a[k]);
            x4[k] = xtime(x2[k]);
            x8[k] = xtime(x4[k]);
        end
        for (int r = 0; r < 4; r++) begin
            res[31 - 8 * r -: 8] =
                  (x8[r] ^ x4[r] ^ x2[r])
                ^ (x8[(r + 1) % 4] ^ x2[(r + 1) % 4] ^ a[(r + 1) % 4])
                ^ (x8[(r + 2) % 4] ^ x4[(r + 2) % 4] ^ a[(r + 2) % 4])
                ^ (x8[(r + 3) % 4] ^ a[(r + 3) % 4]);
        end
        return res;
    endfunction

endpackage

// File: rtl/core/aru_round.sv
// Combinational datapath of one AES round: forward, inverse or key XOR only.
// Depends on aru_pkg for the S-box tables and the MixColumns helpers.
module aru_round (
    input  aru_pkg::t_req   i_req_type,
    input  logic            i_last_round,
    input  aru_pkg::t_block i_state,
    input  aru_pkg::t_block i_key,
    output aru_pkg::t_block o_state
);
    import aru_pkg::*;

    t_byte  s_in  [16];
    t_byte  s_fwd [16];
    t_byte  s_inv [16];
    t_block fwd_sub;
    t_block inv_add;
    t_block fwd_mix;
    t_block inv_mix;

    // Split into bytes, byte 0 at the top
    always_comb begin
        for (int n = 0; n < 16; n++) begin
            s_in[n] = i_state[127 - 8 * n -: 8];
        end
    end

    // SubBytes+ShiftRows and InvShiftRows+InvSubBytes+ARK, column-major layout
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                s_fwd[4 * c + r] = SBOX[s_in[4 * ((c + r) % 4) + r]];
                s_inv[4 * c + r] = REV_SBOX[s_in[4 * ((c + 4 - r) % 4) + r]];
            end
        end
        for (int n = 0; n < 16; n++) begin
            fwd_sub[127 - 8 * n -: 8] = s_fwd[n];
            inv_add[127 - 8 * n -: 8] = s_inv[n] ^ i_key[127 - 8 * n -: 8];
        end
    end

    // Column mixing in both directions
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            fwd_mix[127 - 32 * c -: 32] = mix_col_fwd(fwd_sub[127 - 32 * c -: 32]);
            inv_mix[127 - 32 * c -: 32] = mix_col_inv(inv_add[127 - 32 * c -: 32]);
        end
    end

    // Select the result for the request
    always_comb begin
        case (i_req_type)
            REQ_FWD: o_state = (i_last_round ? fwd_sub : fwd_mix) ^ i_key;
            REQ_INV: o_state = i_last_round ? inv_add : inv_mix;
            default: o_state = i_state ^ i_key;
        endcase
    end

endmodule

// File: rtl/core/aes_round_unit.sv
// AES-128 round unit top level: input register, round datapath, result register.
// Depends on aru_pkg and aru_round.
//
// One AES-128 round per request in FIPS-197 column-major byte order: a forward round
// (SubBytes, ShiftRows, MixColumns unless last, key XOR), an inverse round (InvShiftRows,
// InvSubBytes, key XOR, InvMixColumns unless last) or the key XOR alone. The round logic
// works from the input register and its result lands in the result register, which drives
// o_out_valid. A new request can be taken every cycle; throughput is one request per cycle
// as long as results are taken, set by the single-pass round logic between the two registers.
// Back-pressure on the result side stalls both stages.
module aes_round_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_ready,
    input  logic [1:0]   i_req_type,
    input  logic         i_last_round,
    input  logic [63:0]  i_state_hi,
    input  logic [63:0]  i_state_lo,
    input  logic [63:0]  i_key_hi,
    input  logic [63:0]  i_key_lo,
    output logic         o_out_valid,
    input  logic         i_out_ready,
    output logic [63:0]  o_out_state_hi,
    output logic [63:0]  o_out_state_lo
);
    import aru_pkg::*;

    logic   r_in_valid;
    t_req   r_req_type;
    logic   r_last_round;
    t_block r_state;
    t_block r_key;
    logic   r_out_valid;
    t_block r_result;
    t_block n_result;
    logic   out_free;
    logic   s1_adv;

    // Result register is free when empty or being taken
    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_adv     = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;

    // Capture an accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_req_type   <= t_req'(i_req_type);
            r_last_round <= i_last_round;
            r_state      <= {i_state_hi, i_state_lo};
            r_key        <= {i_key_hi, i_key_lo};
        end
    end

    aru_round u_round (
        .i_req_type   (r_req_type),
        .i_last_round (r_last_round),
        .i_state      (r_state),
        .i_key        (r_key),
        .o_state      (n_result)
    );

    // Advance the round result into the output register, hold on stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_state_hi = r_result[127:64];
    assign o_out_state_lo = r_result[63:0];

    // An accepted request lands in the input register
    a_in_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> r_in_valid)
        else $error("accepted request not captured");

    // A stalled input stage keeps its request
    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !out_free |=> r_in_valid && $stable(r_state) && $stable(r_key))
        else $error("input stage lost a stalled request");

    // Every request that leaves the input stage becomes a visible result
    a_result_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> o_out_valid)
        else $error("result missing after stage advance");

    // Key XOR request gives state XOR key
    a_ark_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv && r_req_type != REQ_FWD && r_req_type != REQ_INV
        |=> r_result == $past(r_state ^ r_key))
        else $error("key XOR result mismatch");

endmodule

// File: verif/aes_round_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for aes_round_unit: directed round requests, then random ones.
// Depends on aru_pkg for the request codes; results are checked against a local round model.
module aes_round_unit_tb;
    import aru_pkg::*;

    localparam int          CLK_HALF       = 2;
    localparam int          RESET_CYCLES   = 10;
    localparam int          N_DIR          = 22;
    localparam int          RAND_PER_PHASE = 260;
    localparam int          N_PHASES       = 3;
    localparam int          HOLD_CYCLES    = 64;
    localparam int          DRAIN_CYCLES   = 8;
    localparam int          CYCLE_LIMIT    = 200000;
    // Unused selector value; the block treats it as key XOR only
    localparam logic [1:0]  REQ_SPARE      = 2'd3;
    localparam logic [7:0]  REDUCE_POLY    = 8'h1b;
    localparam logic [7:0]  AFFINE_CONST   = 8'h63;
    localparam logic [31:0] FWD_COEF       = 32'h02030101;
    localparam logic [31:0] INV_COEF       = 32'h0e0b0d09;

    // One round request; known marks rows whose result is typed into the table
    typedef struct packed {
        logic [1:0]   op;
        logic         last;
        logic [127:0] blk;
        logic [127:0] rkey;
        logic         known;
        logic [127:0] result;
    } t_round_req;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_req_type;
    logic        i_last_round;
    logic [63:0] i_state_hi;
    logic [63:0] i_state_lo;
    logic [63:0] i_key_hi;
    logic [63:0] i_key_lo;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [63:0] o_out_state_hi;
    logic [63:0] o_out_state_lo;

    logic [7:0]   sub_box [256];
    logic [7:0]   inv_box [256];
    logic [127:0] round_exp_q [$];
    logic [127:0] want_blk;
    int           fail_cnt = 0;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    int           hold_reqs = 0;
    int           cycle_cnt;

    t_round_req dir_tab [N_DIR] = '{
        '{REQ_ARK,   1'b0, 128'h0,        128'h0,        1'b1, 128'h0},
        '{REQ_ARK,   1'b0, {16{8'hff}},   128'h0,        1'b1, {16{8'hff}}},
        '{REQ_ARK,   1'b1, {16{8'hff}},   {16{8'hff}},   1'b1, 128'h0},
        '{REQ_ARK,   1'b0, 128'h0123456789abcdef_fedcba9876543210,
          128'hffffffffffffffff_0000000000000000,
          1'b1, 128'hfedcba9876543210_fedcba9876543210},
        '{REQ_SPARE, 1'b0, {16{8'ha5}},   {16{8'h5a}},   1'b1, {16{8'hff}}},
        '{REQ_SPARE, 1'b1, 128'h0,        {16{8'h80}},   1'b1, {16{8'h80}}},
        '{REQ_FWD,   1'b1, 128'h0,        128'h0,        1'b1, {16{8'h63}}},
        '{REQ_FWD,   1'b0, 128'h0,        128'h0,        1'b1, {16{8'h63}}},
        '{REQ_FWD,   1'b0, {16{8'hff}},   128'h0,        1'b1, {16{8'h16}}},
        '{REQ_FWD,   1'b1, {16{8'hff}},   {16{8'hff}},   1'b1, {16{8'he9}}},
        '{REQ_INV,   1'b1, {16{8'h63}},   128'h0,        1'b1, 128'h0},
        '{REQ_INV,   1'b0, {16{8'h63}},   128'h0,        1'b1, 128'h0},
        '{REQ_INV,   1'b0, {16{8'hff}},   128'h0,        1'b1, {16{8'h7d}}},
        '{REQ_INV,   1'b1, {16{8'hff}},   {16{8'hff}},   1'b1, {16{8'h82}}},
        '{REQ_FWD,   1'b0, 128'h193de3bea0f4e22b9ac68d2ae9f84808,
          128'ha0fafe1788542cb123a339392a6c7605, 1'b0, 128'h0},
        '{REQ_FWD,   1'b1, 128'h000102030405060708090a0b0c0d0e0f, 128'h0, 1'b0, 128'h0},
        '{REQ_INV,   1'b1, 128'h000102030405060708090a0b0c0d0e0f, 128'h0, 1'b0, 128'h0},
        '{REQ_FWD,   1'b0, 128'h00112233445566778899aabbccddeeff,
          128'h000102030405060708090a0b0c0d0e0f, 1'b0, 128'h0},
        '{REQ_INV,   1'b0, 128'h00112233445566778899aabbccddeeff,
          128'h000102030405060708090a0b0c0d0e0f, 1'b0, 128'h0},
        '{REQ_FWD,   1'b0, {4{32'h80ff7f01}}, 128'h0,    1'b0, 128'h0},
        '{REQ_INV,   1'b0, {4{32'h80ff7f01}}, 128'h0,    1'b0, 128'h0},
        '{REQ_INV,   1'b1, 128'h69c4e0d86a7b0430d8cdb78070b4c55a,
          128'h13111d7fe3944a17f307a78b4d2b30c5, 1'b0, 128'h0}
    };

    aes_round_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_last_round   (i_last_round),
        .i_state_hi     (i_state_hi),
        .i_state_lo     (i_state_lo),
        .i_key_hi       (i_key_hi),
        .i_key_lo       (i_key_lo),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_state_hi (o_out_state_hi),
        .o_out_state_lo (o_out_state_lo)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Shift-and-add multiply in GF(2^8)
    function automatic logic [7:0] gf_mult(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? REDUCE_POLY : 8'h00);
        end
        return p;
    endfunction

    // Multiply every column by the forward or inverse mixing matrix
    function automatic logic [127:0] mix_state(input logic [127:0] blk, input bit inverse);
        logic [127:0] res;
        logic [31:0]  coef;
        logic [7:0]   acc;
        coef = inverse ? INV_COEF : FWD_COEF;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                acc = 8'h00;
                for (int k = 0; k < 4; k++) begin
                    acc ^= gf_mult(coef[31 - 8 * ((k - r) & 3) -: 8],
                                   blk[127 - 8 * (4 * c + k) -: 8]);
                end
                res[127 - 8 * (4 * c + r) -: 8] = acc;
            end
        end
        return res;
    endfunction

    // Expected state after one round request
    function automatic logic [127:0] predict_round(input logic [1:0] op, input logic last,
                                                   input logic [127:0] blk,
                                                   input logic [127:0] rkey);
        logic [7:0]   s [16];
        logic [127:0] res;
        int           src;
        for (int n = 0; n < 16; n++) begin
            s[n] = blk[127 - 8 * n -: 8];
        end
        case (op)
            REQ_FWD: begin
                // substitute, rotating row r left by r columns
                for (int c = 0; c < 4; c++) begin
                    for (int r = 0; r < 4; r++) begin
                        src = 4 * ((c + r) & 3) + r;
                        res[127 - 8 * (4 * c + r) -: 8] = sub_box[s[src]];
                    end
                end
                if (!last) res = mix_state(res, 1'b0);
                res ^= rkey;
            end
            REQ_INV: begin
                // rotate row r right by r columns, undo the substitution
                for (int c = 0; c < 4; c++) begin
                    for (int r = 0; r < 4; r++) begin
                        src = 4 * ((c + 4 - r) & 3) + r;
                        res[127 - 8 * (4 * c + r) -: 8] = inv_box[s[src]];
                    end
                end
                res ^= rkey;
                if (!last) res = mix_state(res, 1'b1);
            end
            default: begin
                res = blk ^ rkey;
            end
        endcase
        return res;
    endfunction

    // Build the S-box from field inverses and the affine map
    initial begin
        logic [7:0] x;
        for (int i = 0; i < 256; i++) begin
            x = 8'h00;
            for (int j = 1; j < 256; j++) begin
                if (gf_mult(i[7:0], j[7:0]) == 8'h01) x = j[7:0];
            end
            sub_box[i] = x ^ {x[6:0], x[7]} ^ {x[5:0], x[7:6]} ^ {x[4:0], x[7:5]}
                       ^ {x[3:0], x[7:4]} ^ AFFINE_CONST;
            inv_box[sub_box[i]] = i[7:0];
        end
    end

    // Mostly random halves, with all-zero and all-one words mixed in
    function automatic logic [63:0] rand_half();
        case ($urandom_range(15))
            0: return 64'h0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Idle for a while, then offer one request and hold it until accepted
    task automatic issue_request(input t_round_req rq);
        logic [127:0] want;
        want = rq.known ? rq.result : predict_round(rq.op, rq.last, rq.blk, rq.rkey);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        round_exp_q = {round_exp_q, want};
        i_in_valid   <= 1'b1;
        i_req_type   <= rq.op;
        i_last_round <= rq.last;
        i_state_hi   <= rq.blk[127:64];
        i_state_lo   <= rq.blk[63:0];
        i_key_hi     <= rq.rkey[127:64];
        i_key_lo     <= rq.rkey[63:0];
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Result side: random stalls, plus a long hold-off whenever one is requested
    initial begin
        int hold_done;
        hold_done = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_reqs != hold_done) begin
                hold_done++;
                for (int n = 0; n < HOLD_CYCLES; n++) begin
                    i_out_ready <= 1'b0;
                    @(posedge i_clk);
                end
            end
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each accepted result with the oldest expected state
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (round_exp_q.size() == 0) begin
                $error("unexpected result: out_state_hi %h, out_state_lo %h",
                       o_out_state_hi, o_out_state_lo);
                fail_cnt++;
            end else begin
                want_blk = round_exp_q.pop_front();
                if (o_out_state_hi !== want_blk[127:64]) begin
                    $error("out_state_hi mismatch: expected %h, actual %h",
                           want_blk[127:64], o_out_state_hi);
                    fail_cnt++;
                end
                if (o_out_state_lo !== want_blk[63:0]) begin
                    $error("out_state_lo mismatch: expected %h, actual %h",
                           want_blk[63:0], o_out_state_lo);
                    fail_cnt++;
                end
            end
        end
    end

    // Stop a hung run
    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // Request side: reset, directed table, then three random phases
    initial begin
        int          send_idle [N_PHASES];
        int          recv_idle [N_PHASES];
        int          sel;
        t_round_req  rq;
        send_idle = '{29, 79, 0};
        recv_idle = '{79, 29, 0};
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_req_type   <= REQ_FWD;
        i_last_round <= 1'b0;
        i_state_hi   <= 64'h0;
        i_state_lo   <= 64'h0;
        i_key_hi     <= 64'h0;
        i_key_lo     <= 64'h0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = send_idle[0];
        recv_idle_pct = recv_idle[0];
        foreach (dir_tab[i]) begin
            issue_request(dir_tab[i]);
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            send_idle_pct = send_idle[ph];
            recv_idle_pct = recv_idle[ph];
            for (int i = 0; i < RAND_PER_PHASE; i++) begin
                // back up the block while requests keep coming
                if (ph == N_PHASES - 1 && i == 40) hold_reqs++;
                sel = $urandom_range(19);
                rq.op = (sel < 8) ? REQ_FWD : (sel < 16) ? REQ_INV :
                        (sel < 19) ? REQ_ARK : REQ_SPARE;
                rq.last   = $urandom_range(1);
                rq.blk    = {rand_half(), rand_half()};
                rq.rkey   = {rand_half(), rand_half()};
                rq.known  = 1'b0;
                rq.result = 128'h0;
                issue_request(rq);
            end
        end
        i_in_valid <= 1'b0;

        // drain outstanding results, then allow for stragglers
        while (round_exp_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
